>>> design/lobatto_shape_function_eval_top_macros.svh
// Assertion macros for the Lobatto shape function evaluator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LOBATTO_SHAPE_FUNCTION_EVAL_TOP_MACROS_SVH
`define LOBATTO_SHAPE_FUNCTION_EVAL_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LOB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lobatto assertion failed");

// Plain property, checked out of reset.
`define LOB_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lobatto assertion failed");

`endif

>>> design/lob_pkg.sv
// Package for the Lobatto shape function evaluator: widths, context type,
// coefficient and normalization tables and the helper functions on them.
package lob_pkg;

  localparam int MAX_ORDER_DEF = 15;
  localparam int X_FRAC_BITS   = 30;
  localparam int OUT_FRAC_BITS = 26;
  localparam int NUM_CELLS     = 8;
  localparam int NUM_ORDERS    = 16;
  localparam int ACC_W         = 64;
  localparam int MAG_W         = 63;
  localparam int X_W           = 32;
  localparam int MULT_W        = X_W + 1;
  localparam int NORM_W        = 32;
  localparam int NORM_SHIFT    = NORM_W + X_FRAC_BITS - OUT_FRAC_BITS - 1;
  localparam int LATENCY       = 20;

  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);

  typedef logic [3:0] lob_order_t;

  typedef struct packed {
    logic                  valid;
    logic                  err;
    logic                  op;
    lob_order_t            order;
    logic                  xneg;
    logic [X_W-1:0]        ax;
    logic [MULT_W-1:0]     s;
  } lob_ctx_t;

  typedef int lob_coef_row_t [NUM_CELLS];
  typedef lob_coef_row_t lob_coef_tab_t [NUM_ORDERS];
  typedef logic [NORM_W-1:0] lob_norm_tab_t [NUM_ORDERS];

  localparam lob_coef_tab_t LOB_COEF = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{1, -6, 5, 0, 0, 0, 0, 0},
    '{3, -10, 7, 0, 0, 0, 0, 0},
    '{-1, 15, -35, 21, 0, 0, 0, 0},
    '{-5, 35, -63, 33, 0, 0, 0, 0},
    '{5, -140, 630, -924, 429, 0, 0, 0},
    '{35, -420, 1386, -1716, 715, 0, 0, 0},
    '{-7, 315, -2310, 6006, -6435, 2431, 0, 0},
    '{-63, 1155, -6006, 12870, -12155, 4199, 0, 0},
    '{21, -1386, 15015, -60060, 109395, -92378, 29393, 0},
    '{231, -6006, 45045, -145860, 230945, -176358, 52003, 0},
    '{-33, 3003, -45045, 255255, -692835, 969969, -676039, 185725},
    '{-429, 15015, -153153, 692835, -1616615, 2028117, -1300075, 334305}
  };

  localparam int LOB_DEXP [NUM_ORDERS] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8, 8, 10, 10, 11, 11};

  // Evaluated at elaboration only: floor(sqrt((2k-1) * 2^(63-2d))) per order.
  function automatic lob_norm_tab_t lob_build_norm();
    lob_norm_tab_t     tab;
    longint unsigned   n;
    longint unsigned   r;
    longint unsigned   bitv;
    for (int k = 0; k < NUM_ORDERS; k++) begin
      tab[k] = '0;
      if (k >= 2) begin
        n = longint'(2 * k - 1) << (63 - 2 * LOB_DEXP[k]);
        r = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
          end else begin
            r = r >> 1;
          end
          bitv = bitv >> 2;
        end
        tab[k] = NORM_W'(r);
      end
    end
    return tab;
  endfunction

  localparam lob_norm_tab_t LOB_NORM = lob_build_norm();

  // Number of Horner coefficients in use.
  function automatic logic [3:0] lob_cnt(lob_order_t order, logic op);
    logic [3:0] n;
    n = {1'b0, order[3:1]};
    if (order < 4'd2) return 4'd1;
    if (!op || order[0]) return n + 4'd1;
    return n;
  endfunction

  // True when the Horner result still needs one multiply by x.
  function automatic logic lob_odd(lob_order_t order, logic op);
    if (order < 4'd2) return 1'b0;
    return op ? !order[0] : order[0];
  endfunction

  // Coefficient idx of the value or derivative polynomial, scaled to the
  // accumulator's fraction.
  function automatic logic signed [ACC_W-1:0] lob_addend(lob_order_t order, logic op,
                                                        int idx);
    longint d;
    d = 0;
    if (idx >= 0 && idx < NUM_CELLS) begin
      if (!op) begin
        d = longint'(LOB_COEF[order][idx]);
      end else if (order[0]) begin
        d = longint'(2 * idx + 1) * longint'(LOB_COEF[order][idx]);
      end else if (idx + 1 < NUM_CELLS) begin
        d = longint'(2 * (idx + 1)) * longint'(LOB_COEF[order][idx + 1]);
      end
    end
    return ACC_W'(d <<< X_FRAC_BITS);
  endfunction

endpackage

>>> design/lob_front.sv
// Front end of the evaluator: input capture, |x|, x squared and the
// starting accumulator. Depends on lob_pkg.
module lob_front import lob_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    op,
  input  logic [4:0]              order,
  input  logic signed [X_W-1:0]   x_point,
  output lob_ctx_t                ctx_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(longint'(1) <<< X_FRAC_BITS);

  logic                    v0_r;
  logic                    err0_r;
  logic                    op0_r;
  lob_order_t              order0_r;
  logic signed [X_W-1:0]   x0_r;

  lob_ctx_t                ctx_nxt;
  lob_ctx_t                ctx_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic [2*X_W-1:0]        sq;
  logic signed [ACC_W-1:0] xw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err0_r   <= order > 5'(MAX_ORDER);
      op0_r    <= op;
      order0_r <= order[3:0];
      x0_r     <= x_point;
    end
  end

  always_comb begin
    ctx_nxt       = '0;
    ctx_nxt.valid = v0_r;
    ctx_nxt.err   = err0_r;
    ctx_nxt.op    = op0_r;
    ctx_nxt.order = order0_r;
    ctx_nxt.xneg  = x0_r[X_W-1];
    ctx_nxt.ax    = x0_r[X_W-1] ? X_W'(0) - X_W'(x0_r) : X_W'(x0_r);
    sq            = 64'(ctx_nxt.ax) * 64'(ctx_nxt.ax);
    ctx_nxt.s     = sq[X_FRAC_BITS +: MULT_W];
    xw            = ACC_W'(x0_r);
    if (order0_r < 4'd2) begin
      if (op0_r) begin
        acc_nxt = order0_r[0] ? ONE : -ONE;
      end else begin
        acc_nxt = order0_r[0] ? ONE + xw : ONE - xw;
      end
    end else begin
      acc_nxt = lob_addend(order0_r, op0_r, int'(lob_cnt(order0_r, op0_r)) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign ctx_o = ctx_r;
  assign acc_o = acc_r;

endmodule

>>> design/lob_cell.sv
// One cell of the Horner chain: a two-stage multiply, shift, cap and add.
// The last cell multiplies by |x| and restores the sign of x. Depends on lob_pkg.
module lob_cell import lob_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lob_ctx_t                ctx_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output lob_ctx_t                ctx_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam bit ODD_CELL = (CELL_IDX == NUM_CELLS - 1);
  localparam logic signed [ACC_W-1:0] CAP = ACC_W'({1'b0, MAG_CAP});
  localparam int PROD_W = MAG_W + MULT_W;
  localparam int Q_W    = PROD_W - X_FRAC_BITS;

  logic                    neg_a;
  logic [MAG_W-1:0]        mag_a;
  logic [MULT_W-1:0]       mult_a;
  logic                    act_nxt;
  logic [MULT_W+31:0]      plo_nxt;
  logic [MULT_W+MAG_W-33:0] phi_nxt;

  lob_ctx_t                ctx_a_r;
  logic signed [ACC_W-1:0] acc_a_r;
  logic                    neg_a_r;
  logic                    act_a_r;
  logic [MULT_W+31:0]      plo_r;
  logic [MULT_W+MAG_W-33:0] phi_r;

  logic [PROD_W-1:0]       prod;
  logic [Q_W-1:0]          q;
  logic [MAG_W-1:0]        p;
  logic signed [ACC_W-1:0] sp;
  logic signed [ACC_W-1:0] v;
  logic signed [ACC_W-1:0] acc_nxt;
  lob_ctx_t                ctx_r;
  logic signed [ACC_W-1:0] acc_r;

  always_comb begin
    neg_a   = acc_i[ACC_W-1];
    mag_a   = MAG_W'(neg_a ? -acc_i : acc_i);
    mult_a  = ODD_CELL ? {1'b0, ctx_i.ax} : ctx_i.s;
    if (ODD_CELL) begin
      act_nxt = lob_odd(ctx_i.order, ctx_i.op);
    end else begin
      act_nxt = CELL_IDX >= NUM_CELLS - int'(lob_cnt(ctx_i.order, ctx_i.op));
    end
    plo_nxt = (MULT_W+32)'(mag_a[31:0]) * (MULT_W+32)'(mult_a);
    phi_nxt = (MULT_W+MAG_W-32)'(mag_a[MAG_W-1:32]) * (MULT_W+MAG_W-32)'(mult_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_a_r <= '0;
    end else begin
      ctx_a_r <= ctx_i;
    end
  end

  always_ff @(posedge clk) begin
    acc_a_r <= acc_i;
    neg_a_r <= neg_a;
    act_a_r <= act_nxt;
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
  end

  // Magnitude product is capped before the sign and the coefficient go back in.
  always_comb begin
    prod = {phi_r, 32'b0} + PROD_W'(plo_r);
    q    = prod[PROD_W-1:X_FRAC_BITS];
    p    = (q > Q_W'(MAG_CAP)) ? MAG_CAP : q[MAG_W-1:0];
    sp   = neg_a_r ? -ACC_W'({1'b0, p}) : ACC_W'({1'b0, p});
    v    = sp + lob_addend(ctx_a_r.order, ctx_a_r.op, NUM_CELLS - 2 - CELL_IDX);
    if (v > CAP) begin
      v = CAP;
    end else if (v < -CAP) begin
      v = -CAP;
    end
    if (ODD_CELL && ctx_a_r.xneg) begin
      v = -v;
    end
    acc_nxt = act_a_r ? v : acc_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else begin
      ctx_r <= ctx_a_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign ctx_o = ctx_r;
  assign acc_o = acc_r;

endmodule

>>> design/lob_final.sv
// Output stage: scale by the normalization constant, round half away from
// zero, saturate to the result format and apply the sign. Depends on lob_pkg.
module lob_final import lob_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lob_ctx_t                ctx_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic                    strobe,
  output logic signed [31:0]      result_value,
  output logic                    order_error,
  output logic                    saturated
);

  localparam int PROD_W = MAG_W + NORM_W;
  localparam int T_W    = PROD_W - NORM_SHIFT;

  logic                 neg_a;
  logic [MAG_W-1:0]     mag_a;
  logic [NORM_W-1:0]    norm;
  logic [NORM_W+31:0]   plo_nxt;
  logic [PROD_W-33:0]   phi_nxt;

  logic                 v1_r;
  logic                 err1_r;
  logic                 neg1_r;
  logic [NORM_W+31:0]   plo_r;
  logic [PROD_W-33:0]   phi_r;

  logic [PROD_W-1:0]    prod;
  logic [T_W-1:0]       t;
  logic [T_W-1:0]       r;
  logic [T_W-1:0]       lim;
  logic                 sat_nxt;
  logic [31:0]          val_nxt;

  logic                 strobe_r;
  logic [31:0]          val_r;
  logic                 err_r;
  logic                 sat_r;

  always_comb begin
    neg_a   = acc_i[ACC_W-1];
    mag_a   = MAG_W'(neg_a ? -acc_i : acc_i);
    norm    = (ctx_i.order < 4'd2) ? NORM_W'(1) << (NORM_W - 1) : LOB_NORM[ctx_i.order];
    plo_nxt = (NORM_W+32)'(mag_a[31:0]) * (NORM_W+32)'(norm);
    phi_nxt = (PROD_W-32)'(mag_a[MAG_W-1:32]) * (PROD_W-32)'(norm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ctx_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    err1_r <= ctx_i.err;
    neg1_r <= neg_a;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
  end

  // The product is not capped here; only rounding and saturation to the result format remain.
  always_comb begin
    prod    = {phi_r, 32'b0} + PROD_W'(plo_r);
    t       = prod[PROD_W-1:NORM_SHIFT];
    r       = (t + T_W'(1)) >> 1;
    lim     = neg1_r ? T_W'(33'h1_0000_0000 >> 1) : T_W'(32'h7FFF_FFFF);
    sat_nxt = r > lim;
    if (sat_nxt) begin
      r = lim;
    end
    val_nxt = neg1_r ? 32'd0 - r[31:0] : r[31:0];
    if (err1_r) begin
      val_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    err_r <= err1_r;
    sat_r <= sat_nxt;
  end

  assign strobe       = strobe_r;
  assign result_value = val_r;
  assign order_error  = err_r;
  assign saturated    = sat_r;

endmodule

>>> design/lobatto_shape_function_eval_top.sv
// Top level of the Lobatto shape function evaluator: front end, chain of
// Horner cells and output stage. Depends on lob_pkg and the macros header.
//
// Use: drive in_op, in_order and in_x_point (signed, 30 fraction bits) and
// raise start; the beat is taken at the clock edge where start is high and
// busy is low. busy is high while reset is applied and up to the first edge
// after its release, so from then on a new point can be taken at every edge.
// The result beat appears on out_result_value (signed, 26 fraction bits),
// out_order_error and out_saturated with out_strobe high for one cycle,
// once the beat has passed the input register, the front end's x-squared
// register, every cell and the output stage. Results come out in input
// order, one per input, at up to one per cycle.
// The pipeline is the chain: one input stage, one stage for x
// squared, eight cells of two stages each (seven Horner steps and one
// multiply by x), and two stages for normalization and rounding.
// Throughput is one point per clock cycle.
// Reset (rst_n low, synchronous) empties the pipeline; beats in flight are
// dropped. There is no receiver back-pressure: results must be taken when
// the strobe is high.
`include "lobatto_shape_function_eval_top_macros.svh"

module lobatto_shape_function_eval_top import lob_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [4:0]            in_order,
  input  logic signed [X_W-1:0] in_x_point,
  output logic                  out_strobe,
  output logic signed [31:0]    out_result_value,
  output logic                  out_order_error,
  output logic                  out_saturated
);

  logic                    busy_r;
  logic                    accept;
  lob_ctx_t                ctx_c [NUM_CELLS+1];
  logic signed [ACC_W-1:0] acc_c [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  lob_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .op      (in_op),
    .order   (in_order),
    .x_point (in_x_point),
    .ctx_o   (ctx_c[0]),
    .acc_o   (acc_c[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    lob_cell #(.CELL_IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctx_i (ctx_c[g]),
      .acc_i (acc_c[g]),
      .ctx_o (ctx_c[g+1]),
      .acc_o (acc_c[g+1])
    );
  end

  lob_final u_final (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctx_i        (ctx_c[NUM_CELLS]),
    .acc_i        (acc_c[NUM_CELLS]),
    .strobe       (out_strobe),
    .result_value (out_result_value),
    .order_error  (out_order_error),
    .saturated    (out_saturated)
  );

  `LOB_ASSERT_PROP(a_strobe_follows_accept, out_strobe |-> $past(start && !busy, LATENCY))
  `LOB_ASSERT_IMP(a_error_is_zero, out_strobe && out_order_error,
                  out_result_value == 32'sd0 && !out_saturated)
  `LOB_ASSERT_IMP(a_sat_at_limit, out_strobe && out_saturated,
                  out_result_value == 32'sh7FFF_FFFF || out_result_value == 32'sh8000_0000)

endmodule

>>> tb/sv/tb_lobatto_shape_function_eval_top.sv
`timescale 1ns / 1ps
// Testbench for the Lobatto shape function evaluator: directed rows, then random points.
// Depends on lob_pkg and lobatto_shape_function_eval_top; has its own fixed-point predictor.
module tb_lobatto_shape_function_eval_top;
  import lob_pkg::*;

  localparam longint unsigned ACC_CAP = 64'h4000_0000_0000_0000;
  localparam int MAX_CYCLES = 200000;
  localparam int N_RANDOM = 630;

  typedef struct packed {
    logic signed [31:0] val;
    logic               err;
    logic               sat;
  } shape_res_t;

  typedef struct packed {
    logic               op;
    logic [4:0]         order;
    logic [31:0]        x;
    logic               fixed;
    logic signed [31:0] val;
    logic               err;
    logic               sat;
  } dir_row_t;

  localparam int N_DIR = 20;
  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 5'd0, 32'h0000_0000, 1'b1, 32'h0200_0000, 1'b0, 1'b0},
    '{1'b0, 5'd1, 32'h0000_0000, 1'b1, 32'h0200_0000, 1'b0, 1'b0},
    '{1'b1, 5'd0, 32'h0000_3039, 1'b1, 32'hFE00_0000, 1'b0, 1'b0},
    '{1'b1, 5'd1, 32'hFFFF_0000, 1'b1, 32'h0200_0000, 1'b0, 1'b0},
    '{1'b0, 5'd0, 32'h4000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 5'd1, 32'hC000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 5'd0, 32'h8000_0000, 1'b1, 32'h0600_0000, 1'b0, 1'b0},
    '{1'b0, 5'd1, 32'h7FFF_FFFF, 1'b0, 32'h0,        1'b0, 1'b0},
    '{1'b0, 5'd16, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{1'b1, 5'd31, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{1'b0, 5'd15, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd15, 32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd14, 32'h4000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd2, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd3, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd2, 32'hC000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd14, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd13, 32'h2000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd9, 32'hE000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd8, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0}
  };

  int shape_coef [16][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{1, -6, 5, 0, 0, 0, 0, 0},
    '{3, -10, 7, 0, 0, 0, 0, 0},
    '{-1, 15, -35, 21, 0, 0, 0, 0},
    '{-5, 35, -63, 33, 0, 0, 0, 0},
    '{5, -140, 630, -924, 429, 0, 0, 0},
    '{35, -420, 1386, -1716, 715, 0, 0, 0},
    '{-7, 315, -2310, 6006, -6435, 2431, 0, 0},
    '{-63, 1155, -6006, 12870, -12155, 4199, 0, 0},
    '{21, -1386, 15015, -60060, 109395, -92378, 29393, 0},
    '{231, -6006, 45045, -145860, 230945, -176358, 52003, 0},
    '{-33, 3003, -45045, 255255, -692835, 969969, -676039, 185725},
    '{-429, 15015, -153153, 692835, -1616615, 2028117, -1300075, 334305}
  };
  int denom_log2 [16] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8, 8, 10, 10, 11, 11};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [4:0] in_order = '0;
  logic signed [31:0] in_x_point = '0;
  logic out_strobe;
  logic signed [31:0] out_result_value;
  logic out_order_error;
  logic out_saturated;

  shape_res_t pending_q [$];
  int fail_count = 0;
  int cycle_count = 0;

  lobatto_shape_function_eval_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_order(in_order), .in_x_point(in_x_point),
    .out_strobe(out_strobe), .out_result_value(out_result_value),
    .out_order_error(out_order_error), .out_saturated(out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor(a*b / 2^sh), capped at 2^62.
  function automatic longint unsigned scaled_mul(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    if (p[127:64] != 0 || p[63:0] > ACC_CAP) return ACC_CAP;
    return p[63:0];
  endfunction

  function automatic longint horner_mac(longint acc, longint unsigned mult, longint addend);
    longint unsigned mag;
    longint v;
    mag = (acc < 0) ? longint'(-acc) : acc;
    v = longint'(scaled_mul(mag, mult, X_FRAC_BITS));
    if (acc < 0) v = -v;
    v = v + addend;
    if (v > longint'(ACC_CAP)) v = longint'(ACC_CAP);
    if (v < -longint'(ACC_CAP)) v = -longint'(ACC_CAP);
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic shape_res_t shape_eval(logic op, logic [4:0] order, logic [31:0] xbits);
    shape_res_t res;
    longint x, acc, one, d [8];
    longint unsigned ax, s, norm, mag, t, r, lim;
    int n, cnt, k;
    logic odd;
    res = '0;
    if (order > 5'd15) begin
      res.err = 1'b1;
      return res;
    end
    k = order;
    x = longint'($signed(xbits));
    ax = (x < 0) ? -x : x;
    one = longint'(1) << X_FRAC_BITS;
    if (k < 2) begin
      norm = 64'h8000_0000;
      if (op) acc = k ? one : -one;
      else acc = k ? one + x : one - x;
    end else begin
      n = k / 2;
      odd = 1'b0;
      for (int i = 0; i < 8; i++) d[i] = 0;
      if (!op) begin
        for (int i = 0; i <= n; i++) d[i] = shape_coef[k][i];
        cnt = n + 1;
        odd = k[0];
      end else if (k[0]) begin
        for (int i = 0; i <= n; i++) d[i] = longint'(2 * i + 1) * shape_coef[k][i];
        cnt = n + 1;
      end else begin
        for (int i = 0; i < n; i++) d[i] = longint'(2 * (i + 1)) * shape_coef[k][i + 1];
        cnt = n;
        odd = 1'b1;
      end
      s = scaled_mul(ax, ax, X_FRAC_BITS);
      acc = d[cnt - 1] * one;
      for (int i = cnt - 1; i > 0; i--) acc = horner_mac(acc, s, d[i - 1] * one);
      if (odd) begin
        acc = horner_mac(acc, ax, 0);
        if (x < 0) acc = -acc;
      end
      norm = int_sqrt(longint'(2 * k - 1) << (63 - 2 * denom_log2[k]));
    end
    mag = (acc < 0) ? -acc : acc;
    t = scaled_mul(mag, norm, 32 + X_FRAC_BITS - OUT_FRAC_BITS - 1);
    r = (t + 1) >> 1;
    lim = (acc < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (r > lim) begin
      r = lim;
      res.sat = 1'b1;
    end
    res.val = (acc < 0) ? 32'(-r) : 32'(r);
    return res;
  endfunction

  task automatic send_point(logic op, logic [4:0] order, logic [31:0] x, logic fixed,
                            shape_res_t fixed_res);
    int gap;
    in_op <= op;
    in_order <= order;
    in_x_point <= x;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(fixed ? fixed_res : shape_eval(op, order, x));
    // Mostly back to back; sometimes short gaps, rarely long ones.
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    shape_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat val=%0d err=%0b sat=%0b", $time,
                 out_result_value, out_order_error, out_saturated);
        fail_count++;
      end else begin
        exp_res = pending_q.pop_front();
        if (out_result_value !== exp_res.val) begin
          $display("%0t: result_value expected %0d actual %0d", $time, exp_res.val,
                   out_result_value);
          fail_count++;
        end
        if (out_order_error !== exp_res.err) begin
          $display("%0t: order_error expected %0b actual %0b", $time, exp_res.err,
                   out_order_error);
          fail_count++;
        end
        if (out_saturated !== exp_res.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_res.sat,
                   out_saturated);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    shape_res_t fixed_res;
    logic [4:0] ord;
    logic [31:0] xv;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      fixed_res = '{dir_rows[i].val, dir_rows[i].err, dir_rows[i].sat};
      send_point(dir_rows[i].op, dir_rows[i].order, dir_rows[i].x, dir_rows[i].fixed,
                 fixed_res);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      ord = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
      // Most points lie in the element; the rest cover the whole Q2.30 range.
      if ($urandom_range(0, 4) == 0) xv = $urandom;
      else xv = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      send_point(1'($urandom), ord, xv, 1'b0, '0);
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
